FILE: hw/rtl/pcx_pkg.sv
`timescale 1ns / 1ps

package pcx_pkg;

  // Field widths fixed by the item format.
  localparam int CFG_W   = 13;
  localparam int POS_W   = 12;
  localparam int RUN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int COLOR_W = 3 * BYTE_W;

  // Palette geometry.
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);

  // Bytes at or above this mark are run counts.
  localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;

  // Request kinds on the input channel.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_CODE = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  // Decoder control states.
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Position of the byte slot that is placed next.
  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             done;
  } pix_pos_t;

endpackage

FILE: hw/rtl/pcx_if.sv
`timescale 1ns / 1ps

// Input channel: palette loads and coded image bytes.
interface pcx_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [pcx_pkg::BYTE_W-1:0] palette_index;
  logic [pcx_pkg::BYTE_W-1:0] color_first;
  logic [pcx_pkg::BYTE_W-1:0] color_second;
  logic [pcx_pkg::BYTE_W-1:0] color_third;
  logic [pcx_pkg::BYTE_W-1:0] code_byte;

  modport source (
    output valid, action, palette_index, color_first, color_second, color_third, code_byte,
    input  ready
  );
  modport sink (
    input  valid, action, palette_index, color_first, color_second, color_third, code_byte,
    output ready
  );
endinterface

// Result channel: one decoded pixel per transfer.
interface pcx_out_if;
  logic                       valid;
  logic                       ready;
  logic [pcx_pkg::POS_W-1:0]  pixel_column;
  logic [pcx_pkg::POS_W-1:0]  pixel_row;
  logic [pcx_pkg::BYTE_W-1:0] out_first;
  logic [pcx_pkg::BYTE_W-1:0] out_second;
  logic [pcx_pkg::BYTE_W-1:0] out_third;
  logic                       image_done;

  modport source (
    output valid, pixel_column, pixel_row, out_first, out_second, out_third, image_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_column, pixel_row, out_first, out_second, out_third, image_done,
    output ready
  );
endinterface

// Configuration write channel.
interface pcx_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pcx_pkg::CFG_IDX_W-1:0] index;
  logic [pcx_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/pcx_ram.sv
`timescale 1ns / 1ps

module pcx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/pcx_cfg.sv
`timescale 1ns / 1ps

module pcx_cfg #(
  parameter int MAX_DIMENSION = 4096,
  parameter int DIM_W         = $clog2(MAX_DIMENSION + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  pcx_cfg_if.sink          cfg_ch,
  output logic [DIM_W-1:0] line_bytes,
  output logic [DIM_W-1:0] image_width,
  output logic [DIM_W-1:0] image_height
);

  logic [pcx_pkg::CFG_W-1:0] line_bytes_r,   line_bytes_nxt;
  logic [pcx_pkg::CFG_W-1:0] image_width_r,  image_width_nxt;
  logic [pcx_pkg::CFG_W-1:0] image_height_r, image_height_nxt;

  // A zero register reads as one; a register above the limit reads as the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [pcx_pkg::CFG_W-1:0] v);
    if (v == '0) begin
      clamp_dim = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIMENSION)) begin
      clamp_dim = DIM_W'(MAX_DIMENSION);
    end else begin
      clamp_dim = DIM_W'(v);
    end
  endfunction

  assign cfg_ch.ready = 1'b1;

  // Register write decode; unknown indexes are dropped.
  always_comb begin
    line_bytes_nxt   = line_bytes_r;
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        pcx_pkg::CFG_LINE_BYTES:   line_bytes_nxt   = cfg_ch.data;
        pcx_pkg::CFG_IMAGE_WIDTH:  image_width_nxt  = cfg_ch.data;
        pcx_pkg::CFG_IMAGE_HEIGHT: image_height_nxt = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r   <= pcx_pkg::CFG_W'(1);
      image_width_r  <= pcx_pkg::CFG_W'(1);
      image_height_r <= pcx_pkg::CFG_W'(1);
    end else begin
      line_bytes_r   <= line_bytes_nxt;
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
    end
  end

  assign line_bytes   = clamp_dim(line_bytes_r);
  assign image_width  = clamp_dim(image_width_r);
  assign image_height = clamp_dim(image_height_r);

endmodule

FILE: hw/rtl/pcx_walk.sv
`timescale 1ns / 1ps

module pcx_walk #(
  parameter int MAX_DIMENSION = 4096,
  parameter int DIM_W         = $clog2(MAX_DIMENSION + 1),
  parameter int CNT_W         = $clog2(MAX_DIMENSION)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              place,
  input  logic [DIM_W-1:0]  line_bytes,
  input  logic [DIM_W-1:0]  image_width,
  input  logic [DIM_W-1:0]  image_height,
  output pcx_pkg::pix_pos_t pos
);

  logic [CNT_W-1:0] byte_r, byte_nxt;
  logic [CNT_W-1:0] line_r, line_nxt;
  logic             finished_r, finished_nxt;

  logic [DIM_W-1:0] byte_ext;
  logic [DIM_W-1:0] line_ext;
  logic [DIM_W-1:0] byte_inc;
  logic [DIM_W-1:0] last_row;
  logic [DIM_W-1:0] last_col;
  logic             live;

  // Where the current slot lies and whether it produces a pixel.
  always_comb begin
    byte_ext = DIM_W'(byte_r);
    line_ext = DIM_W'(line_r);
    byte_inc = byte_ext + DIM_W'(1);
    last_row = image_height - DIM_W'(1);
    last_col = ((image_width < line_bytes) ? image_width : line_bytes) - DIM_W'(1);
    live     = !finished_r && (line_ext < image_height);
    pos.emit = live && (byte_ext < image_width);
    pos.col  = pcx_pkg::POS_W'(byte_r);
    pos.row  = pcx_pkg::POS_W'(last_row - line_ext);
    pos.done = (line_ext == last_row) && (byte_ext == last_col);
  end

  // Advance one slot, wrapping at the end of the line and stopping after the last line.
  always_comb begin
    byte_nxt     = byte_r;
    line_nxt     = line_r;
    finished_nxt = finished_r;
    if (place) begin
      if (!live) begin
        finished_nxt = 1'b1;
      end else if (byte_inc >= line_bytes) begin
        byte_nxt = '0;
        if (line_ext >= last_row) begin
          finished_nxt = 1'b1;
        end else begin
          line_nxt = line_r + CNT_W'(1);
        end
      end else begin
        byte_nxt = CNT_W'(byte_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r     <= '0;
      line_r     <= '0;
      finished_r <= 1'b0;
    end else begin
      byte_r     <= byte_nxt;
      line_r     <= line_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

FILE: hw/rtl/pcx_rle_palette_decoder.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake               Payload
// in_ch    in   valid/ready             action, palette_index, color_*, code_byte
// out_ch   out  valid/ready             pixel_column, pixel_row, out_*, image_done
// cfg_ch   in   valid/ready (ready=1)   index, data (13 bits)
//
// A palette load or a run-count byte is taken in ST_IDLE and places no slot. A literal
// byte reads the palette, then its slot is placed from ST_EMIT. A run value byte with
// count n reads the single palette read port once, then the line walker places n byte
// slots, one slot per cycle unless held; no request is taken meanwhile. A stalled result
// holds the walker only when the slot would emit a pixel; padding slots keep moving.
// Reset clears the decoding state and registers; the palette is not cleared.

module pcx_rle_palette_decoder #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  pcx_in_if.sink     in_ch,
  pcx_out_if.source  out_ch,
  pcx_cfg_if.sink    cfg_ch
);

  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int CNT_W = $clog2(MAX_DIMENSION);

  pcx_pkg::state_t state_r, state_nxt;

  logic [pcx_pkg::RUN_W-1:0] run_left_r, run_left_nxt;
  logic                      awaiting_r, awaiting_nxt;
  logic [pcx_pkg::RUN_W-1:0] count_r,    count_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [pcx_pkg::POS_W-1:0]   col_r, row_r;
  logic [pcx_pkg::COLOR_W-1:0] color_r;
  logic                        done_r;

  logic [DIM_W-1:0] line_bytes, image_width, image_height;

  logic                        in_acc;
  logic                        load_acc;
  logic                        code_acc;
  logic                        start;
  logic                        slot_free;
  logic                        place;
  logic [pcx_pkg::COLOR_W-1:0] pal_rdata;
  pcx_pkg::pix_pos_t           pos;

  // Configuration registers.
  pcx_cfg #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .DIM_W         (DIM_W)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ch       (cfg_ch),
    .line_bytes   (line_bytes),
    .image_width  (image_width),
    .image_height (image_height)
  );

  // Request decode.
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign load_acc = in_acc && (in_ch.action == pcx_pkg::ACT_LOAD);
  assign code_acc = in_acc && (in_ch.action == pcx_pkg::ACT_CODE);
  assign start    = code_acc && (awaiting_r ? (run_left_r != '0)
                                            : (in_ch.code_byte < pcx_pkg::RUN_MARK));

  // Palette memory: loads write, a decoded index reads once for the whole run.
  pcx_ram #(
    .WIDTH (pcx_pkg::COLOR_W),
    .DEPTH (pcx_pkg::PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (load_acc),
    .waddr (in_ch.palette_index),
    .wdata ({in_ch.color_first, in_ch.color_second, in_ch.color_third}),
    .re    (start),
    .raddr (in_ch.code_byte),
    .rdata (pal_rdata)
  );

  // Line and image position.
  pcx_walk #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .DIM_W         (DIM_W),
    .CNT_W         (CNT_W)
  ) u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .place        (place),
    .line_bytes   (line_bytes),
    .image_width  (image_width),
    .image_height (image_height),
    .pos          (pos)
  );

  assign slot_free = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcx_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = pcx_pkg::ST_EMIT;
        end
      end
      pcx_pkg::ST_EMIT: begin
        if (place && (count_r == pcx_pkg::RUN_W'(1))) begin
          state_nxt = pcx_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pcx_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    place       = 1'b0;
    unique case (state_r)
      pcx_pkg::ST_IDLE: in_ch.ready = 1'b1;
      pcx_pkg::ST_EMIT: place       = !pos.emit || slot_free;
      default: ;
    endcase
  end

  // Run tracking and slot count.
  always_comb begin
    run_left_nxt = run_left_r;
    awaiting_nxt = awaiting_r;
    count_nxt    = count_r;
    if (code_acc) begin
      if (awaiting_r) begin
        awaiting_nxt = 1'b0;
        run_left_nxt = '0;
        count_nxt    = run_left_r;
      end else if (in_ch.code_byte < pcx_pkg::RUN_MARK) begin
        count_nxt = pcx_pkg::RUN_W'(1);
      end else begin
        awaiting_nxt = 1'b1;
        run_left_nxt = in_ch.code_byte[pcx_pkg::RUN_W-1:0];
      end
    end else if (place) begin
      count_nxt = count_r - pcx_pkg::RUN_W'(1);
    end
  end

  // Result register.
  assign out_valid_nxt = (place && pos.emit) ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcx_pkg::ST_IDLE;
      run_left_r  <= '0;
      awaiting_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_left_r  <= run_left_nxt;
      awaiting_r  <= awaiting_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (place && pos.emit) begin
      col_r   <= pos.col;
      row_r   <= pos.row;
      color_r <= pal_rdata;
      done_r  <= pos.done;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_column = col_r;
  assign out_ch.pixel_row    = row_r;
  assign out_ch.out_first    = color_r[3*pcx_pkg::BYTE_W-1:2*pcx_pkg::BYTE_W];
  assign out_ch.out_second   = color_r[2*pcx_pkg::BYTE_W-1:pcx_pkg::BYTE_W];
  assign out_ch.out_third    = color_r[pcx_pkg::BYTE_W-1:0];
  assign out_ch.image_done   = done_r;

endmodule

FILE: bench/pcx_rle_palette_decoder_tb.sv
`timescale 1ns / 1ps

module pcx_rle_palette_decoder_tb;

  localparam int DIM_MAX       = 4096;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 4000;

  typedef struct {
    logic                       action;
    logic [pcx_pkg::BYTE_W-1:0] pal_idx;
    logic [pcx_pkg::BYTE_W-1:0] first;
    logic [pcx_pkg::BYTE_W-1:0] second;
    logic [pcx_pkg::BYTE_W-1:0] third;
    logic [pcx_pkg::BYTE_W-1:0] code;
  } request_t;

  typedef struct packed {
    logic [pcx_pkg::POS_W-1:0]  col;
    logic [pcx_pkg::POS_W-1:0]  row;
    logic [pcx_pkg::BYTE_W-1:0] first;
    logic [pcx_pkg::BYTE_W-1:0] second;
    logic [pcx_pkg::BYTE_W-1:0] third;
    logic                       done;
  } pixel_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  pcx_in_if  in_ch ();
  pcx_out_if out_ch ();
  pcx_cfg_if cfg_ch ();

  pcx_rle_palette_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the decoder: palette, registers and line walker.
  logic [pcx_pkg::COLOR_W-1:0] palette_shadow [pcx_pkg::PAL_DEPTH];
  logic [pcx_pkg::CFG_W-1:0]   line_bytes_reg = 1;
  logic [pcx_pkg::CFG_W-1:0]   width_reg      = 1;
  logic [pcx_pkg::CFG_W-1:0]   height_reg     = 1;
  logic [pcx_pkg::RUN_W-1:0]   run_count      = '0;
  bit                          want_value     = 1'b0;
  bit                          image_closed   = 1'b0;
  int unsigned                 slot_col       = 0;
  int unsigned                 line_no        = 0;

  request_t    pending_requests [$];
  pixel_t      expected_pixels [$];
  request_t    on_bus;
  logic [7:0]  loaded_list [$];
  bit          loaded_map [pcx_pkg::PAL_DEPTH];
  bit          gen_want_value = 1'b0;
  bit          calm = 1'b0;

  int errors        = 0;
  int pixels_seen   = 0;
  int done_seen     = 0;
  int requests_seen = 0;
  int loads_seen    = 0;
  int reg_writes    = 0;
  int stall_cycles  = 0;

  function automatic int unsigned clamp_dim(logic [pcx_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  // Place one decoded index in the current line slot; visible slots make a pixel.
  task automatic place_slot(logic [pcx_pkg::BYTE_W-1:0] idx);
    int unsigned lb, w, h, last_col;
    pixel_t px;
    lb = clamp_dim(line_bytes_reg);
    w  = clamp_dim(width_reg);
    h  = clamp_dim(height_reg);
    last_col = ((w < lb) ? w : lb) - 1;
    if (image_closed || line_no >= h) begin
      image_closed = 1'b1;
      return;
    end
    if (slot_col < w) begin
      px.col  = pcx_pkg::POS_W'(slot_col);
      px.row  = pcx_pkg::POS_W'(h - 1 - line_no);
      {px.first, px.second, px.third} = palette_shadow[idx];
      px.done = (line_no == h - 1) && (slot_col == last_col);
      expected_pixels.push_back(px);
    end
    slot_col++;
    if (slot_col >= lb) begin
      slot_col = 0;
      if (line_no >= h - 1) image_closed = 1'b1;
      else line_no++;
    end
  endtask

  // Work out the pixels that one accepted request produces.
  task automatic apply_request(request_t r);
    if (r.action == pcx_pkg::ACT_LOAD) begin
      palette_shadow[r.pal_idx] = {r.first, r.second, r.third};
      loads_seen++;
    end else if (want_value) begin
      want_value = 1'b0;
      repeat (run_count) place_slot(r.code);
      run_count = '0;
    end else if (r.code < pcx_pkg::RUN_MARK) begin
      place_slot(r.code);
    end else begin
      run_count  = pcx_pkg::RUN_W'(r.code - pcx_pkg::RUN_MARK);
      want_value = 1'b1;
    end
  endtask

  function automatic void queue_load(logic [7:0] idx, logic [7:0] f, logic [7:0] s,
                                     logic [7:0] t);
    request_t r;
    r.action  = pcx_pkg::ACT_LOAD;
    r.pal_idx = idx;
    r.first   = f;
    r.second  = s;
    r.third   = t;
    r.code    = 8'($urandom);
    pending_requests.push_back(r);
    if (!loaded_map[idx]) begin
      loaded_map[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endfunction

  // Coded byte request; the unused palette fields carry random noise.
  function automatic void queue_code(logic [7:0] code);
    request_t r;
    r.action  = pcx_pkg::ACT_CODE;
    r.pal_idx = 8'($urandom);
    r.first   = 8'($urandom);
    r.second  = 8'($urandom);
    r.third   = 8'($urandom);
    r.code    = code;
    pending_requests.push_back(r);
    gen_want_value = !gen_want_value && (code >= pcx_pkg::RUN_MARK);
  endfunction

  // Only palette entries that have been loaded are ever used as pixel values.
  function automatic logic [7:0] pick_index(bit literal_only);
    logic [7:0] idx;
    for (int k = 0; k < 64; k++) begin
      idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      if (!literal_only || idx < pcx_pkg::RUN_MARK) return idx;
    end
    return 8'h00;
  endfunction

  task automatic random_requests(int count);
    for (int n = 0; n < count; n++) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)
        queue_load(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else if (gen_want_value)
        queue_code(pick_index(1'b0));
      else if (pick < 60)
        queue_code(pick_index(1'b1));
      else
        queue_code(8'($urandom_range(pcx_pkg::RUN_MARK, 8'hFF)));
    end
  endtask

  task automatic write_reg(logic [pcx_pkg::CFG_IDX_W-1:0] idx,
                           logic [pcx_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      pcx_pkg::CFG_LINE_BYTES:   line_bytes_reg = value;
      pcx_pkg::CFG_IMAGE_WIDTH:  width_reg      = value;
      pcx_pkg::CFG_IMAGE_HEIGHT: height_reg     = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Wait until every request is taken and every pixel is back, then let the
  // walker finish any padding slots.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_ch.valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request driver: predicts on acceptance, then offers the next pending request.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_request(on_bus);
        requests_seen++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
          on_bus = pending_requests.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.action        <= on_bus.action;
          in_ch.palette_index <= on_bus.pal_idx;
          in_ch.color_first   <= on_bus.first;
          in_ch.color_second  <= on_bus.second;
          in_ch.color_third   <= on_bus.third;
          in_ch.code_byte     <= on_bus.code;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor: compares each accepted pixel with the oldest expected one.
  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.col    = out_ch.pixel_column;
        got.row    = out_ch.pixel_row;
        got.first  = out_ch.out_first;
        got.second = out_ch.out_second;
        got.third  = out_ch.out_third;
        got.done   = out_ch.image_done;
        pixels_seen++;
        if (got.done) done_seen++;
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel col %0d row %0d rgb %h %h %h done %0b",
                   $time, got.col, got.row, got.first, got.second, got.third, got.done);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: pixel mismatch, expected col %0d row %0d rgb %h %h %h done %0b,%s",
                     $time, want.col, want.row, want.first, want.second, want.third,
                     want.done,
                     $sformatf(" got col %0d row %0d rgb %h %h %h done %0b",
                               got.col, got.row, got.first, got.second, got.third,
                               got.done));
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  // Watchdog on cycles with no handshake on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d pixels still expected",
                 $time, STALL_LIMIT, expected_pixels.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = pcx_pkg::CFG_LINE_BYTES;
    cfg_ch.data         = '0;
    in_ch.valid         = 1'b0;
    in_ch.action        = pcx_pkg::ACT_LOAD;
    in_ch.palette_index = '0;
    in_ch.color_first   = '0;
    in_ch.color_second  = '0;
    in_ch.color_third   = '0;
    in_ch.code_byte     = '0;
    out_ch.ready        = 1'b0;
    for (int i = 0; i < pcx_pkg::PAL_DEPTH; i++) begin
      palette_shadow[i] = '0;
      loaded_map[i]     = 1'b0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: color extremes, literals at both ends, zero and full runs,
    // runs that cross lines, and a load between a run count and its value.
    write_reg(pcx_pkg::CFG_LINE_BYTES, 13'd5);
    write_reg(pcx_pkg::CFG_IMAGE_WIDTH, 13'd3);
    write_reg(pcx_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
    @(negedge clk);
    queue_load(8'h00, 8'h00, 8'h00, 8'h00);
    queue_load(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_load(8'hBF, 8'hA5, 8'h5A, 8'hC3);
    queue_load(8'h40, 8'h12, 8'h34, 8'h56);
    queue_load(8'h80, 8'h80, 8'h01, 8'h7F);
    queue_load(8'h15, 8'hFE, 8'h01, 8'hAA);
    queue_code(8'h00);
    queue_code(8'hBF);
    queue_code(8'h40);
    queue_code(8'hC0);
    queue_code(8'hFF);
    queue_code(8'hC3);
    queue_code(8'hFF);
    queue_code(8'h80);
    queue_code(8'hFF);
    queue_code(8'h15);
    queue_code(8'hC1);
    queue_code(8'h00);
    queue_code(8'h15);
    queue_code(8'hC5);
    queue_load(8'h2A, 8'h3C, 8'hC3, 8'h99);
    queue_code(8'h2A);
    wait_idle();

    // One-byte lines with a width far beyond them.
    write_reg(pcx_pkg::CFG_LINE_BYTES, 13'd0);
    write_reg(pcx_pkg::CFG_IMAGE_WIDTH, 13'h1FFF);
    @(negedge clk);
    random_requests(25);
    wait_idle();

    // Widest lines, with no idling on either side.
    write_reg(pcx_pkg::CFG_LINE_BYTES, 13'h1FFF);
    write_reg(pcx_pkg::CFG_IMAGE_WIDTH, 13'd4096);
    write_reg(pcx_pkg::CFG_IMAGE_HEIGHT, 13'd4096);
    @(negedge clk);
    calm = 1'b1;
    random_requests(100);
    wait_idle();
    calm = 1'b0;

    // Shorter lines with padding; the walker is likely past the new line end.
    write_reg(pcx_pkg::CFG_LINE_BYTES, 13'($urandom_range(16, 64)));
    write_reg(pcx_pkg::CFG_IMAGE_WIDTH, 13'($urandom_range(1, line_bytes_reg)));
    write_reg(pcx_pkg::CFG_IMAGE_HEIGHT, 13'h1FFF);
    @(negedge clk);
    random_requests(140);
    wait_idle();

    // Very short lines with a zero width.
    write_reg(pcx_pkg::CFG_LINE_BYTES, 13'($urandom_range(2, 12)));
    write_reg(pcx_pkg::CFG_IMAGE_WIDTH, 13'd0);
    @(negedge clk);
    random_requests(100);
    wait_idle();

    // Close the image a few lines on, with a width beyond the line length;
    // the bytes after the end must produce nothing.
    write_reg(pcx_pkg::CFG_LINE_BYTES, 13'd4);
    write_reg(pcx_pkg::CFG_IMAGE_WIDTH, 13'd7);
    write_reg(pcx_pkg::CFG_IMAGE_HEIGHT, 13'(line_no + 3));
    @(negedge clk);
    random_requests(60);
    wait_idle();

    // Height dropped below the current line after the image has ended.
    write_reg(pcx_pkg::CFG_LINE_BYTES, 13'd4096);
    write_reg(pcx_pkg::CFG_IMAGE_HEIGHT, 13'd0);
    @(negedge clk);
    random_requests(20);
    wait_idle();

    $display("Covered %0d requests (%0d palette loads), %0d pixels checked, %0d reg writes.",
             requests_seen, loads_seen, pixels_seen, reg_writes);
    $display("Image end flag seen %0d time(s); decoder ended on line %0d of the image.",
             done_seen, line_no);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pcx_pkg.sv
hw/rtl/pcx_if.sv
hw/rtl/pcx_ram.sv
hw/rtl/pcx_cfg.sv
hw/rtl/pcx_walk.sv
hw/rtl/pcx_rle_palette_decoder.sv
bench/pcx_rle_palette_decoder_tb.sv
